@@ sv/tcf_pkg.sv @@
// Package for the tilt complementary filter: widths, register indexes,
// reset values, sequencer states and the CORDIC arctangent table.
// No dependencies; imported by tcf_cordic and tilt_complementary_filter_core.
`default_nettype none

package tcf_pkg;

  // Number of CORDIC iterations (valid range 8 to 24)
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;

  // Datapath widths
  localparam int SMP_W  = 16;  // raw samples
  localparam int XY_W   = 39;  // CORDIC x/y, samples scaled by 2^20 plus growth
  localparam int ANG_W  = 27;  // CORDIC angle accumulator, 1/65536 degree
  localparam int ACC_W  = 17;  // accelerometer angle, 1/256 degree
  localparam int ANGO_W = 24;  // gyro and fused angles
  localparam int DIFF_W = 17;  // gyro sample minus offset
  localparam int MA_W   = 25;  // shared multiplier operand A (signed)
  localparam int MB_W   = 18;  // shared multiplier operand B (signed)
  localparam int MP_W   = MA_W + MB_W;
  localparam int SUM_W  = 28;  // pre-saturation sums

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 65536);
  localparam int ACC_LIMIT = 46080;
  localparam logic [ACC_W-1:0] ALPHA_ONE = ACC_W'(65536);

  // Configuration register indexes
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 17;
  localparam logic [CFG_AW-1:0] REG_GYRO_OFFSET  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GYRO_GAIN    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ACCEL_WEIGHT = 2'd2;

  // Reset values of the registers
  localparam logic signed [15:0] GYRO_OFFSET_RST  = 16'sd16;
  localparam logic [15:0]        GYRO_GAIN_RST    = 16'd512;
  localparam logic [16:0]        ACCEL_WEIGHT_RST = 17'd852;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GMUL,
    S_GSUM,
    S_WAIT,
    S_FMUL,
    S_FSUM
  } tcf_state_e;

  // Arctangent of 2^-i in 1/65536 degree, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // Saturate a sum to the 24-bit angle range
  function automatic logic signed [ANGO_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [ANGO_W-1:0] r;
    if (v > SUM_W'(8388607)) begin
      r = 24'sh7FFFFF;
    end else if (v < -SUM_W'(8388608)) begin
      r = 24'sh800000;
    end else begin
      r = v[ANGO_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/tcf_cordic.sv @@
// Iterative vectoring CORDIC: one shift-add step per cycle, giving the
// accelerometer tilt -atan2(ax, az) in 1/256 degree.
// Depends on tcf_pkg for widths and the arctangent table.
`default_nettype none

module tcf_cordic import tcf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SMP_W-1:0] ax_i,
  input  wire logic signed [SMP_W-1:0] az_i,
  output logic                         valid_o,
  output logic signed [ACC_W-1:0]      angle_o
);

  logic signed [XY_W-1:0]  x_q, y_q;
  logic signed [XY_W-1:0]  x_ld, y_ld;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] z_q, z_ld, z_rnd;
  logic signed [ANG_W-9:0] z_sh;
  logic signed [ANG_W-8:0] r_neg;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, valid_q, zero_q;

  // Load values: scale by 2^20, turn by half a turn when az is negative
  always_comb begin
    x_ld = XY_W'(az_i) <<< 20;
    y_ld = XY_W'(ax_i) <<< 20;
    z_ld = '0;
    if (az_i < 0) begin
      x_ld = -x_ld;
      y_ld = -y_ld;
      z_ld = (ax_i >= 0) ? HALF_TURN : -HALF_TURN;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;

  // Control: count iterations, hold valid until the next start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end
    end
  end

  // Datapath: rotate toward the x axis, accumulate the angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_ld;
      y_q    <= y_ld;
      z_q    <= z_ld;
      zero_q <= (ax_i == '0) && (az_i == '0);
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_lut(ATAN_IDX_W'(cnt_q));
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_lut(ATAN_IDX_W'(cnt_q));
      end
    end
  end

  // Round to 1/256 degree, negate and clamp
  always_comb begin
    z_rnd = z_q + ANG_W'(128);
    z_sh  = z_rnd[ANG_W-1:8];
    r_neg = -(ANG_W-7)'(z_sh);
    if (zero_q) begin
      angle_o = '0;
    end else if (r_neg > (ANG_W-7)'(ACC_LIMIT)) begin
      angle_o = ACC_W'(ACC_LIMIT);
    end else if (r_neg < -(ANG_W-7)'(ACC_LIMIT)) begin
      angle_o = -ACC_W'(ACC_LIMIT);
    end else begin
      angle_o = r_neg[ACC_W-1:0];
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ sv/tilt_complementary_filter_core.sv @@
// Tilt complementary filter top level: configuration registers, sequencer,
// shared multiplier, output register. Uses tcf_pkg and tcf_cordic.
//
// Usage:
//   s_axis carries one IMU sample per item (accel_x, accel_z, gyro_y).
//   m_axis returns one result per item (angle_accel, gyro_track,
//   angle_fused), all in 1/256 degree.
//   The cfg port writes gyro_offset, gyro_gain and accel_weight, one per
//   cycle with cfg_we_i high; write only while the block is idle.
// Timing:
//   An item passes through the sequencer states GMUL, GSUM, WAIT, FMUL and
//   FSUM to the output register; the CORDIC iteration loop, one step per
//   cycle, sets how long WAIT lasts. The gyro multiply shares its cycles
//   with the CORDIC; the blend multiply follows it on the same multiplier.
//   s_axis_tready is high only while the sequencer is idle, so a new item
//   is taken only after the last result is loaded into the output register.
// Reset:
//   Registers return to offset 16, gain 512, weight 852; the fused angle
//   clears to zero and no result is pending.
// Stall:
//   A result waits in the output register; the next item is accepted
//   meanwhile, and its result holds in the sequencer until the register frees.
`default_nettype none

module tilt_complementary_filter_core import tcf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input items
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [47:0]       s_axis_tdata,   // accel_x, accel_z, gyro_y
  // Result items
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [71:0]            m_axis_tdata,   // angle_accel, gyro_track, angle_fused, 0 pad
  // Configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [CFG_DW-1:0] cfg_wdata_i
);

  tcf_state_e state_q, state_d;

  logic signed [15:0]        gyro_offset_q;
  logic [15:0]               gyro_gain_q;
  logic [16:0]               accel_weight_q;
  logic [ACC_W-1:0]          alpha;

  logic signed [SMP_W-1:0]   ax, az, gy;
  logic                      in_acc, out_load;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    mul_p, mul_q, step_w;
  logic signed [SUM_W-1:0]   gsum;
  logic signed [ANGO_W-1:0]  gyro_q, fused_q, fused_new;
  logic signed [ACC_W-1:0]   acc_q, cord_angle;
  logic signed [MP_W:0]      fsum;
  logic                      cord_valid;

  logic                      m_valid_q;
  logic [71:0]               m_data_q;

  assign ax = s_axis_tdata[15:0];
  assign az = s_axis_tdata[31:16];
  assign gy = s_axis_tdata[47:32];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_offset_q  <= GYRO_OFFSET_RST;
      gyro_gain_q    <= GYRO_GAIN_RST;
      accel_weight_q <= ACCEL_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GYRO_OFFSET:  gyro_offset_q  <= cfg_wdata_i[15:0];
        REG_GYRO_GAIN:    gyro_gain_q    <= cfg_wdata_i[15:0];
        REG_ACCEL_WEIGHT: accel_weight_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the weight to one
  assign alpha = (accel_weight_q > ALPHA_ONE) ? ALPHA_ONE : accel_weight_q;

  tcf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .ax_i    (ax),
    .az_i    (az),
    .valid_o (cord_valid),
    .angle_o (cord_angle)
  );

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_GMUL;
      S_GMUL: state_d = S_GSUM;
      S_GSUM: state_d = S_WAIT;
      S_WAIT: if (cord_valid) state_d = S_FMUL;
      S_FMUL: state_d = S_FSUM;
      S_FSUM: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared multiplier operands: gyro step, then blend
  always_comb begin
    case (state_q)
      S_GMUL: begin
        mul_a = MA_W'(diff_q);
        mul_b = MB_W'({2'b00, gyro_gain_q});
      end
      S_FMUL: begin
        mul_a = MA_W'(acc_q) - MA_W'(gyro_q);
        mul_b = MB_W'({1'b0, alpha});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // Gyro prediction and blend sums
  always_comb begin
    step_w    = (mul_q + MP_W'(16384)) >>> 15;
    gsum      = SUM_W'(fused_q) + step_w[SUM_W-1:0];
    fsum      = ((MP_W+1)'(gyro_q) <<< 16) + (MP_W+1)'(mul_q) + (MP_W+1)'(32768);
    fused_new = sat24(fsum[SUM_W+15:16]);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q <= DIFF_W'(gy) - DIFF_W'(gyro_offset_q);
    end
    if (state_q == S_GMUL || state_q == S_FMUL) begin
      mul_q <= mul_p;
    end
    if (state_q == S_GSUM) begin
      gyro_q <= sat24(gsum);
    end
    if (state_q == S_WAIT && cord_valid) begin
      acc_q <= cord_angle;
    end
    if (out_load) begin
      m_data_q <= {7'd0, fused_new, gyro_q, acc_q};
    end
  end

  // Fused angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fused_q <= '0;
    end else if (out_load) begin
      fused_q <= fused_new;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // The fused angle moves only when a result is loaded
  a_fused_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fused_q != $past(fused_q)) |-> $past(out_load))
    else $error("fused angle changed without a result load");

  // The blend multiply starts only with a finished CORDIC angle
  a_fmul_after_cordic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FMUL) |-> cord_valid)
    else $error("blend started before the CORDIC finished");

  // An accepted item starts the gyro multiply next cycle
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_GMUL) && !cord_valid)
    else $error("accepted item did not start the sequencer");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for tilt_complementary_filter_core: a directed table of
// samples and register writes, then random phases under several settings.
// Depends on tcf_pkg and the core RTL only.
`default_nettype none

module testbench;
  import tcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 8;
  localparam int NUM_ROWS        = 25;
  localparam int SETTLE_CYCLES   = CORDIC_STEPS + 24;
  localparam int MAX_REPORTS     = 10;
  localparam longint ANGLE_MAX   = 8388607;
  localparam longint ANGLE_MIN   = -8388608;
  localparam longint TILT_LIMIT  = 46080;
  localparam longint WEIGHT_ONE  = 65536;

  // Index past the register list; writes to it must be ignored
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  // Arctangent of 2^-i in 1/65536 degree
  localparam longint ATAN_STEP [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [ANGO_W-1:0] fused;
    logic signed [ANGO_W-1:0] gyro;
    logic signed [ACC_W-1:0]  accel;
  } tilt_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_AW-1:0]  addr;
    logic [CFG_DW-1:0]  wdata;
    logic [SMP_W-1:0]   ax;
    logic [SMP_W-1:0]   az;
    logic [SMP_W-1:0]   gy;
    logic               typed;
    tilt_result_t       want;
  } stim_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata  = '0;   // accel_x, accel_z, gyro_y
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [71:0]       m_axis_tdata;         // angle_accel, gyro_track, angle_fused, 0 pad
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i    = '0;
  logic [CFG_DW-1:0] cfg_wdata_i   = '0;

  // Shadow registers and filter state of the predictor
  longint cfg_offset  = 16;
  longint cfg_gain    = 512;
  longint cfg_weight  = 852;
  longint fused_state = 0;

  tilt_result_t pending_angles[$];
  stim_row_t    directed_rows [NUM_ROWS];

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hit_top      = 1'b0;
  bit hit_bottom   = 1'b0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_writes     = 0;
  int n_errors     = 0;

  tilt_complementary_filter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_angle(input longint v);
    if (v > ANGLE_MAX) begin
      return ANGLE_MAX;
    end else if (v < ANGLE_MIN) begin
      return ANGLE_MIN;
    end
    return v;
  endfunction

  // Tilt as -atan2(ax, az) by vectoring CORDIC, in 1/256 degree
  function automatic longint accel_tilt(input logic signed [SMP_W-1:0] ax,
                                        input logic signed [SMP_W-1:0] az);
    longint x, y, z, dx, dy, r;
    int     n, i;
    x = longint'(az) * 1048576;
    y = longint'(ax) * 1048576;
    z = 0;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (ax == 0 && az == 0) begin
      return 0;
    end
    // Turn left half-plane vectors by a half turn first
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end
    end
    r = -((z + 128) >>> 8);
    if (r > TILT_LIMIT) r = TILT_LIMIT;
    if (r < -TILT_LIMIT) r = -TILT_LIMIT;
    return r;
  endfunction

  // Blend one sample into the fused angle and return the three angles
  function automatic tilt_result_t fuse_sample(input logic [SMP_W-1:0] ax,
                                               input logic [SMP_W-1:0] az,
                                               input logic [SMP_W-1:0] gy);
    tilt_result_t res;
    longint       acc, step, gyro, fused, alpha;
    alpha = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_weight;
    acc   = accel_tilt(ax, az);
    step  = ((longint'($signed(gy)) - cfg_offset) * cfg_gain + 16384) >>> 15;
    gyro  = clamp_angle(fused_state + step);
    fused = clamp_angle((alpha * acc + (WEIGHT_ONE - alpha) * gyro + 32768) >>> 16);
    fused_state = fused;
    if (fused == ANGLE_MAX) hit_top = 1'b1;
    if (fused == ANGLE_MIN) hit_bottom = 1'b1;
    res.accel = acc[ACC_W-1:0];
    res.gyro  = gyro[ANGO_W-1:0];
    res.fused = fused[ANGO_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t row_write(input logic [CFG_AW-1:0] addr,
                                          input logic [CFG_DW-1:0] data);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.addr  = addr;
    r.wdata = data;
    return r;
  endfunction

  function automatic stim_row_t row_sample(input logic [SMP_W-1:0] ax,
                                           input logic [SMP_W-1:0] az,
                                           input logic [SMP_W-1:0] gy);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_SAMPLE;
    r.ax   = ax;
    r.az   = az;
    r.gy   = gy;
    return r;
  endfunction

  // Sample row with the expected angles written out
  function automatic stim_row_t row_known(input logic [SMP_W-1:0] ax,
                                          input logic [SMP_W-1:0] az,
                                          input logic [SMP_W-1:0] gy,
                                          input int acc, input int gyro,
                                          input int fused);
    stim_row_t r;
    r            = row_sample(ax, az, gy);
    r.typed      = 1'b1;
    r.want.accel = acc[ACC_W-1:0];
    r.want.gyro  = gyro[ANGO_W-1:0];
    r.want.fused = fused[ANGO_W-1:0];
    return r;
  endfunction

  // Mostly uniform, with extremes, zero and small values mixed in
  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then queue its prediction
  task automatic send_sample(input logic [SMP_W-1:0] ax, input logic [SMP_W-1:0] az,
                             input logic [SMP_W-1:0] gy, input logic typed,
                             input tilt_result_t want);
    tilt_result_t pred;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gy, az, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = fuse_sample(ax, az, gy);
    pending_angles.push_back(typed ? want : pred);
    n_sent++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (addr)
      REG_GYRO_OFFSET:  cfg_offset = longint'($signed(data[15:0]));
      REG_GYRO_GAIN:    cfg_gain   = longint'(data[15:0]);
      REG_ACCEL_WEIGHT: cfg_weight = longint'(data);
      default: ;
    endcase
    n_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------

  initial begin
    tilt_result_t want, got;
    int           stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(tilt_result_t)-1:0];
        if (pending_angles.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: result with nothing expected: accel %0d gyro %0d fused %0d",
                     $realtime, got.accel, got.gyro, got.fused);
          end
        end else begin
          want = pending_angles.pop_front();
          n_checked++;
          if (got.accel !== want.accel || got.gyro !== want.gyro ||
              got.fused !== want.fused) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: result %0d mismatch: accel %0d/%0d gyro %0d/%0d fused %0d/%0d",
                       $realtime, n_checked, got.accel, want.accel, got.gyro,
                       want.gyro, got.fused, want.fused);
            end
          end
        end
      end
      // Drop ready in random bursts
      if (stall_left == 0 && sink_idle_en && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t        row;
    logic [SMP_W-1:0] gy;
    int               p;

    directed_rows = '{
      row_known (16'h0000, 16'h0000, 16'h0010, 0, 0, 0),
      // Weight above one behaves as one, and no gyro step: fused follows tilt
      row_write (REG_ACCEL_WEIGHT, 17'h1FFFF),
      row_write (REG_GYRO_GAIN, 17'h00000),
      row_known (16'h0000, 16'h8000, 16'h8000, -46080, 0, -46080),
      row_known (16'h0000, 16'h0000, 16'h7FFF, 0, -46080, 0),
      row_known (16'h0000, 16'hFFFF, 16'h0000, -46080, 0, -46080),
      row_known (16'h0000, 16'h0000, 16'h0000, 0, -46080, 0),
      // Axis extremes and all four quadrants
      row_sample(16'h8000, 16'h0000, 16'h0000),
      row_sample(16'h7FFF, 16'h0000, 16'h0000),
      row_sample(16'h7FFF, 16'h7FFF, 16'h1234),
      row_sample(16'h8000, 16'h8000, 16'h0000),
      row_sample(16'hFFFF, 16'h8000, 16'h0000),
      row_sample(16'h0001, 16'h8000, 16'h0000),
      row_sample(16'h8000, 16'h7FFF, 16'h0000),
      row_sample(16'h0001, 16'h0001, 16'h0000),
      row_sample(16'h7FFF, 16'h0001, 16'h0000),
      // Full gain, gyro only, offset at both ends
      row_write (REG_GYRO_GAIN, 17'h0FFFF),
      row_write (REG_GYRO_OFFSET, 17'h08000),
      row_write (REG_ACCEL_WEIGHT, 17'h00000),
      row_sample(16'h0000, 16'h0000, 16'h7FFF),
      row_sample(16'h0000, 16'h0000, 16'h8000),
      row_write (REG_GYRO_OFFSET, 17'h07FFF),
      row_sample(16'h0000, 16'h0000, 16'h8000),
      // Write past the register list leaves everything as it was
      row_write (REG_UNUSED, 17'h1FFFF),
      row_sample(16'h0000, 16'h0000, 16'h8000)
    };

    // Reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.addr, row.wdata);
      end else begin
        send_sample(row.ax, row.az, row.gy, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      src_idle_en  = (p != 5) && (p != NUM_PHASES - 1);
      sink_idle_en = (p != 6) && (p != NUM_PHASES - 1);
      case (p)
        0: begin
          write_reg(REG_GYRO_OFFSET, CFG_DW'($urandom_range(0, 64) - 32));
          write_reg(REG_GYRO_GAIN, 17'd512);
          write_reg(REG_ACCEL_WEIGHT, 17'd852);
        end
        // Drive the fused angle into the top, then the bottom, limit
        1: begin
          write_reg(REG_GYRO_OFFSET, 17'h08000);
          write_reg(REG_GYRO_GAIN, 17'h0FFFF);
          write_reg(REG_ACCEL_WEIGHT, 17'd0);
        end
        2: begin
          write_reg(REG_GYRO_OFFSET, 17'h07FFF);
          write_reg(REG_GYRO_GAIN, 17'h0FFFF);
          write_reg(REG_ACCEL_WEIGHT, 17'd0);
        end
        3: begin
          write_reg(REG_GYRO_OFFSET, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_GYRO_GAIN, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_ACCEL_WEIGHT, 17'd65536);
        end
        6: begin
          write_reg(REG_GYRO_OFFSET, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_GYRO_GAIN, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_ACCEL_WEIGHT, CFG_DW'($urandom_range(0, 4096)));
        end
        default: begin
          write_reg(REG_GYRO_OFFSET, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_GYRO_GAIN, CFG_DW'($urandom_range(0, 131071)));
          write_reg(REG_ACCEL_WEIGHT, CFG_DW'($urandom_range(0, 131071)));
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if (p == 1) begin
          gy = 16'($urandom);
        end else if (p == 2) begin
          gy = 16'(32'd0 - $urandom_range(0, 32768));
        end else begin
          gy = pick_sample();
        end
        send_sample(pick_sample(), pick_sample(), gy, 1'b0, '0);
      end
    end

    // Wind down and report
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d results, %0d register writes in %0d phases.",
             n_sent, n_checked, n_writes, NUM_PHASES + 1);
    $display("Fused angle reached top limit: %0d, bottom limit: %0d; failures: %0d.",
             hit_top, hit_bottom, n_errors);
    if (n_errors == 0 && pending_angles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_angles.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
